// ===== rtl/core/i2cbs_pkg.sv =====
package i2cbs_pkg;

    localparam int BITS_PER_BYTE = 8;

    // bus command codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_SEND  = 2'd2;
    localparam logic [1:0] OP_ACK   = 2'd3;

    // ack status codes
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_ACKED   = 2'd1;
    localparam logic [1:0] ST_WAITING = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_SETUP_HOLD  = 2'd0;
    localparam logic [1:0] REG_BIT_HALF    = 2'd1;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;

    localparam logic [7:0] SETUP_HOLD_RST  = 8'd4;
    localparam logic [7:0] BIT_HALF_RST    = 8'd2;
    localparam logic [7:0] RETRY_LIMIT_RST = 8'd250;

    localparam int PHASE_IDX_W = 5;
    localparam logic [PHASE_IDX_W-1:0] SEND_RUN_LEN = PHASE_IDX_W'(1 + 3 * BITS_PER_BYTE);

    // run kinds decided by the front end
    typedef enum logic [2:0] {
        K_START,
        K_STOP,
        K_SEND,
        K_ACK_OK,
        K_ACK_WAIT,
        K_ACK_TIMEOUT
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic                     fresh;
        logic [BITS_PER_BYTE-1:0] tx_byte;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_q_rd;

    function automatic logic [1:0] kind_status(input t_kind kind);
        logic [1:0] st;
        unique case (kind)
            K_ACK_OK:      st = ST_ACKED;
            K_ACK_WAIT:    st = ST_WAITING;
            K_ACK_TIMEOUT: st = ST_TIMEOUT;
            default:       st = ST_NONE;
        endcase
        return st;
    endfunction

    function automatic logic [PHASE_IDX_W-1:0] run_len(input t_kind kind, input logic fresh);
        logic [PHASE_IDX_W-1:0] len;
        unique case (kind)
            K_START:       len = PHASE_IDX_W'(3);
            K_STOP:        len = PHASE_IDX_W'(2);
            K_SEND:        len = SEND_RUN_LEN;
            K_ACK_OK:      len = fresh ? PHASE_IDX_W'(3) : PHASE_IDX_W'(1);
            K_ACK_WAIT:    len = fresh ? PHASE_IDX_W'(2) : PHASE_IDX_W'(1);
            K_ACK_TIMEOUT: len = fresh ? PHASE_IDX_W'(4) : PHASE_IDX_W'(2);
            default:       len = PHASE_IDX_W'(1);
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/i2cbs_if.sv =====
interface i2cbs_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] tx_byte;
    logic       sda_sample;

    modport source (output valid, output operation, output tx_byte, output sda_sample,
                    input ready);
    modport sink (input valid, input operation, input tx_byte, input sda_sample,
                  output ready);
endinterface

interface i2cbs_phase_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_release;
    logic [7:0] hold_units;
    logic [1:0] ack_status;
    logic       last_phase;

    modport source (output valid, output scl_level, output sda_release, output hold_units,
                    output ack_status, output last_phase, input ready);
    modport sink (input valid, input scl_level, input sda_release, input hold_units,
                  input ack_status, input last_phase, output ready);
endinterface

// ===== rtl/core/i2cbs_front.sv =====
module i2cbs_front
    import i2cbs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    i2cbs_cmd_if.sink       i_cmd,
    input  logic [7:0]      i_retry_limit,
    input  logic            i_q_full,
    output logic            o_q_push,
    output t_desc           o_q_desc
);

    logic [7:0] r_retry;
    logic [7:0] n_retry;
    logic [8:0] next_cnt;
    logic       fresh;
    logic       accept;

    assign i_cmd.ready = !i_q_full;
    assign accept      = i_cmd.valid && !i_q_full;
    assign o_q_push    = accept;
    assign fresh       = (r_retry == 8'd0);
    assign next_cnt    = {1'b0, r_retry} + 9'd1;

    always_comb begin
        o_q_desc.fresh   = fresh;
        o_q_desc.tx_byte = i_cmd.tx_byte;
        o_q_desc.kind    = K_START;
        n_retry          = 8'd0;
        unique case (i_cmd.operation)
            OP_START: o_q_desc.kind = K_START;
            OP_STOP:  o_q_desc.kind = K_STOP;
            OP_SEND:  o_q_desc.kind = K_SEND;
            OP_ACK: begin
                if (!i_cmd.sda_sample) begin
                    o_q_desc.kind = K_ACK_OK;
                end else if (next_cnt > {1'b0, i_retry_limit}) begin
                    o_q_desc.kind = K_ACK_TIMEOUT;
                end else begin
                    o_q_desc.kind = K_ACK_WAIT;
                    n_retry       = next_cnt[7:0];
                end
            end
            default: o_q_desc.kind = K_START;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry <= 8'd0;
        end else if (accept) begin
            r_retry <= n_retry;
        end
    end

endmodule

// ===== rtl/core/i2cbs_queue.sv =====
module i2cbs_queue
    import i2cbs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output t_q_rd o_rd
);

    t_desc      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full     = (r_count == 2'd2);
    assign o_rd.valid = (r_count != 2'd0);
    assign o_rd.desc  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/i2cbs_back.sv =====
module i2cbs_back
    import i2cbs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_q_rd         i_q_rd,
    output logic          o_q_pop,
    input  logic [7:0]    i_setup_hold,
    input  logic [7:0]    i_bit_half,
    i2cbs_phase_if.source o_phase
);

    // position inside one bit of a byte
    localparam logic [1:0] SUB_LOW_PRE  = 2'd0;
    localparam logic [1:0] SUB_HIGH     = 2'd1;
    localparam logic [1:0] SUB_LOW_POST = 2'd2;

    logic                     r_busy;
    t_kind                    r_kind;
    logic                     r_fresh;
    logic [BITS_PER_BYTE-1:0] r_shift;
    logic [1:0]               r_sub;
    logic [PHASE_IDX_W-1:0]   r_idx;

    logic                     r_out_valid;
    logic                     r_scl;
    logic                     r_sda;
    logic [7:0]               r_hold;
    logic [1:0]               r_status;
    logic                     r_last;

    logic                     emit;
    logic                     last;
    logic                     load;
    logic [PHASE_IDX_W-1:0]   ack_j;
    logic                     ph_scl;
    logic                     ph_sda;
    logic [7:0]               ph_hold;

    assign emit    = r_busy && (!r_out_valid || o_phase.ready);
    assign last    = (r_idx == run_len(r_kind, r_fresh) - PHASE_IDX_W'(1));
    assign load    = i_q_rd.valid && (!r_busy || (emit && last));
    assign o_q_pop = load;
    assign ack_j   = r_fresh ? r_idx - PHASE_IDX_W'(2) : r_idx;

    always_comb begin
        ph_scl  = 1'b0;
        ph_sda  = 1'b1;
        ph_hold = i_bit_half;
        unique case (r_kind)
            K_START: begin
                ph_scl  = (r_idx != PHASE_IDX_W'(2));
                ph_sda  = (r_idx == PHASE_IDX_W'(0));
                ph_hold = (r_idx == PHASE_IDX_W'(2)) ? 8'd0 : i_setup_hold;
            end
            K_STOP: begin
                ph_scl  = (r_idx == PHASE_IDX_W'(1));
                ph_sda  = (r_idx == PHASE_IDX_W'(1));
                ph_hold = i_setup_hold;
            end
            K_SEND: begin
                if (r_idx == PHASE_IDX_W'(0)) begin
                    ph_scl  = 1'b0;
                    ph_sda  = 1'b0;
                    ph_hold = 8'd0;
                end else begin
                    ph_scl  = (r_sub == SUB_HIGH);
                    ph_sda  = r_shift[BITS_PER_BYTE-1];
                    ph_hold = i_bit_half;
                end
            end
            default: begin
                // ack runs: release prefix on a fresh poll, then the outcome
                if (r_fresh && r_idx < PHASE_IDX_W'(2)) begin
                    ph_scl  = (r_idx == PHASE_IDX_W'(1));
                    ph_sda  = 1'b1;
                    ph_hold = i_bit_half;
                end else if (r_kind == K_ACK_OK) begin
                    ph_scl  = 1'b0;
                    ph_sda  = 1'b1;
                    ph_hold = 8'd0;
                end else if (r_kind == K_ACK_WAIT) begin
                    ph_scl  = 1'b1;
                    ph_sda  = 1'b1;
                    ph_hold = i_bit_half;
                end else begin
                    ph_scl  = (ack_j == PHASE_IDX_W'(1));
                    ph_sda  = (ack_j == PHASE_IDX_W'(1));
                    ph_hold = i_setup_hold;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_sub       <= SUB_LOW_PRE;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_sub  <= SUB_LOW_PRE;
            end else if (emit) begin
                if (last) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + PHASE_IDX_W'(1);
                if (r_kind == K_SEND && r_idx != PHASE_IDX_W'(0)) begin
                    r_sub <= (r_sub == SUB_LOW_POST) ? SUB_LOW_PRE : r_sub + 2'd1;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_phase.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // run descriptor and shift register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= i_q_rd.desc.kind;
            r_fresh <= i_q_rd.desc.fresh;
            r_shift <= i_q_rd.desc.tx_byte;
        end else if (emit && r_kind == K_SEND && r_idx != PHASE_IDX_W'(0)
                     && r_sub == SUB_LOW_POST) begin
            r_shift <= {r_shift[BITS_PER_BYTE-2:0], 1'b0};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_scl    <= ph_scl;
            r_sda    <= ph_sda;
            r_hold   <= ph_hold;
            r_status <= kind_status(r_kind);
            r_last   <= last;
        end
    end

    assign o_phase.valid       = r_out_valid;
    assign o_phase.scl_level   = r_scl;
    assign o_phase.sda_release = r_sda;
    assign o_phase.hold_units  = r_hold;
    assign o_phase.ack_status  = r_status;
    assign o_phase.last_phase  = r_last;

endmodule

// ===== rtl/core/i2c_master_bit_sequencer_core.sv =====
// the first line phase of a command passes through the command queue, the run registers and the output register
// one line phase per cycle while the output is not stalled by ready; the phase count of each run
//   (start 3, stop 2, send 25, ack check 1 to 4) is set by the phase expander
// a two-entry command queue lets commands be taken while the expander is busy
// reset (synchronous, active low): queue and output empty, retry count zero,
//   registers back to setup hold 4, bit half 2, retry limit 250
module i2c_master_bit_sequencer_core
    import i2cbs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2cbs_cmd_if.sink     i_cmd,
    i2cbs_phase_if.source o_phase,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    // configuration registers, to be written only while the block is idle; the block does not enforce this
    logic [7:0] r_setup_hold;
    logic [7:0] r_bit_half;
    logic [7:0] r_retry_limit;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    // queue between front end and phase expander
    logic       q_push;
    t_desc      q_desc;
    logic       q_full;
    logic       q_pop;
    t_q_rd      q_rd;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup_hold  <= SETUP_HOLD_RST;
            r_bit_half    <= BIT_HALF_RST;
            r_retry_limit <= RETRY_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SETUP_HOLD:  r_setup_hold  <= pwdata[7:0];
                REG_BIT_HALF:    r_bit_half    <= pwdata[7:0];
                REG_RETRY_LIMIT: r_retry_limit <= pwdata[7:0];
                default: ; // unmapped address, write dropped
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_SETUP_HOLD:  prdata = {24'd0, r_setup_hold};
            REG_BIT_HALF:    prdata = {24'd0, r_bit_half};
            REG_RETRY_LIMIT: prdata = {24'd0, r_retry_limit};
            default:         prdata = 32'd0;
        endcase
    end

    // front end: takes commands, keeps the retry count, picks the run kind
    i2cbs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_retry_limit (r_retry_limit),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_desc      (q_desc)
    );

    i2cbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rd    (q_rd)
    );

    // back end: expands each run into line phases behind an output register
    i2cbs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_rd       (q_rd),
        .o_q_pop      (q_pop),
        .i_setup_hold (r_setup_hold),
        .i_bit_half   (r_bit_half),
        .o_phase      (o_phase)
    );

endmodule
